// ----- hdl/scdr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scdr_pkg
// Shared types, constants and arithmetic helpers for the scattering
// direction rotation pipeline (all inner values are Q30 fixed point).
// ----------------------------------------------------------------------------
package scdr_pkg;

    localparam int DIR_FRAC_BITS   = 16;
    localparam int ANGLE_FRAC_BITS = 13;

    localparam int QB        = 30;
    localparam int QW        = 34;
    localparam int SER_TERMS = 7;
    localparam int SER_SUB   = 4;
    localparam int SER_N     = SER_TERMS * SER_SUB;
    localparam int ROOT_BITS = 31;
    localparam int SQ_W      = 62;

    typedef logic signed [QW-1:0] t_q;

    localparam t_q Q_ONE     = 34'sd1073741824;
    localparam t_q HALF_PI_Q = 34'sd1686629713;
    localparam t_q HALF_H    = 34'sd843314856;
    localparam t_q PI_Q      = 34'sd3373259426;
    localparam t_q THREE_H   = 34'sd5059889139;

    localparam logic signed [2*QW-1:0] MUL_BIAS = 68'sd1073741823;

    typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} t_quad;

    typedef struct packed {
        t_q    r;
        t_quad quad;
    } t_red;

    typedef struct packed {
        t_q    r2;
        t_quad quad;
    } t_side;

    typedef struct packed {
        logic signed [61:0] prod;
        logic [29:0]        mag;
        logic               neg;
        logic [29:0]        q0;
        t_q                 term;
        t_q                 sum;
    } t_lane;

    typedef struct packed {
        logic [SQ_W-1:0]      rem;
        logic [ROOT_BITS-1:0] root;
    } t_sq;

    typedef struct packed {
        t_q u1;
        t_q u2;
        t_q u3;
    } t_dir;

    typedef struct packed {
        t_q cth;
        t_q sph;
        t_q cph;
    } t_pc;

    // q30 product, truncated toward zero
    function automatic t_q mulq(input t_q a, input t_q b);
        logic signed [2*QW-1:0] p;
        p = a * b;
        if (p[2*QW-1]) begin
            p = p + MUL_BIAS;
        end
        p = p >>> QB;
        return p[QW-1:0];
    endfunction

    // one root bit of an exact integer square root
    function automatic t_sq sqrt_step(input t_sq x, input int b);
        logic [SQ_W-1:0] trial;
        t_sq             y;
        y     = x;
        trial = (SQ_W'(x.root) << (b + 1)) + (SQ_W'(1) << (2 * b));
        if (x.rem >= trial) begin
            y.rem  = x.rem - trial;
            y.root = x.root | (ROOT_BITS'(1) << b);
        end
        return y;
    endfunction

    // range reduction by half pi, quadrant from k mod 4
    function automatic t_red reduce(input t_q x);
        t_q               y;
        t_q               kh;
        logic [1:0]       kp;
        logic [1:0]       kn;
        logic signed [3:0] k;
        t_red             o;
        y  = x + HALF_H;
        kp = 2'(y >= HALF_PI_Q) + 2'(y >= PI_Q) + 2'(y >= THREE_H);
        kn = 2'(y < 0) + 2'(y < -HALF_PI_Q) + 2'(y < -PI_Q);
        k  = $signed({2'b00, kp}) - $signed({2'b00, kn});
        unique case (k)
            4'sd3:   kh = THREE_H;
            4'sd2:   kh = PI_Q;
            4'sd1:   kh = HALF_PI_Q;
            -4'sd1:  kh = -HALF_PI_Q;
            -4'sd2:  kh = -PI_Q;
            -4'sd3:  kh = -THREE_H;
            default: kh = '0;
        endcase
        o.r    = x - kh;
        o.quad = t_quad'(k[1:0]);
        return o;
    endfunction

    function automatic t_q pick_sin(input t_quad q, input t_q s, input t_q c);
        t_q v;
        unique case (q)
            QUAD_0:  v = s;
            QUAD_1:  v = c;
            QUAD_2:  v = -s;
            default: v = -c;
        endcase
        return v;
    endfunction

    function automatic t_q pick_cos(input t_quad q, input t_q s, input t_q c);
        t_q v;
        unique case (q)
            QUAD_0:  v = c;
            QUAD_1:  v = -s;
            QUAD_2:  v = -c;
            default: v = s;
        endcase
        return v;
    endfunction

endpackage

// ----- hdl/scatter_direction_rotate.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scatter_direction_rotate
// Applies one scattering event (polar and azimuthal angle) to a unit
// direction vector and returns the new direction, saturated to +-1.0.
// ----------------------------------------------------------------------------
// usage:
//   input beat : i_old_x/y/z (signed q1.F), i_polar_angle (unsigned q2.A),
//                i_azimuth_angle (signed q2.A), taken when i_valid & o_ready
//   output beat: o_new_x/y/z (signed q1.F), taken when o_valid & i_ready
//   pipeline   : one-bit-per-stage root units (31 stages each; the ux^2 + uy^2
//                root runs beside the taylor series, the sin theta root after
//                it) and the restoring divider (33 + DIR_FRAC_BITS stages)
//   throughput : one beat per cycle when not stalled; every stage is a register
//                with a valid bit and all stages advance together
//   stall      : while o_valid is high and i_ready low the whole pipeline
//                holds and o_ready drops; nothing is lost or repeated
//   reset      : i_rst_n low clears all valid bits; no beat is in flight
//                afterward and the block accepts input on the next cycle
// ----------------------------------------------------------------------------
module scatter_direction_rotate #(
    parameter int DIR_FRAC_BITS   = scdr_pkg::DIR_FRAC_BITS,
    parameter int ANGLE_FRAC_BITS = scdr_pkg::ANGLE_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [DIR_FRAC_BITS+1:0]   i_old_x,
    input  logic signed [DIR_FRAC_BITS+1:0]   i_old_y,
    input  logic signed [DIR_FRAC_BITS+1:0]   i_old_z,
    input  logic        [ANGLE_FRAC_BITS+1:0] i_polar_angle,
    input  logic signed [ANGLE_FRAC_BITS+2:0] i_azimuth_angle,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [DIR_FRAC_BITS+1:0]   o_new_x,
    output logic signed [DIR_FRAC_BITS+1:0]   o_new_y,
    output logic signed [DIR_FRAC_BITS+1:0]   o_new_z
);

    localparam int DW     = DIR_FRAC_BITS + 2;
    localparam int DSH    = scdr_pkg::QB - DIR_FRAC_BITS;
    localparam int ASH    = scdr_pkg::QB - ANGLE_FRAC_BITS;
    localparam int DQ_W   = 33 + DIR_FRAC_BITS;
    localparam int WW     = DQ_W + 2;
    localparam int RB     = scdr_pkg::ROOT_BITS;
    localparam int SN     = scdr_pkg::SER_N;
    localparam int ST_SQ0 = 34;
    localparam int ST_SQL = 65;
    localparam int ST_DV0 = 68;
    localparam int ST_DVL = ST_DV0 + DQ_W;
    localparam int LAST   = ST_DVL + 2;

    localparam logic signed [DW-1:0] D_ONE = {2'b01, {DIR_FRAC_BITS{1'b0}}};
    localparam logic signed [WW-1:0] W_ONE = WW'(64'd1 << DIR_FRAC_BITS);
    localparam logic signed [WW-1:0] W_RND = WW'((64'd1 << DSH) - 64'd1);

    typedef logic signed [WW-1:0] t_w;

    typedef struct packed {
        scdr_pkg::t_q px;
        scdr_pkg::t_q py;
        scdr_pkg::t_q pz;
        scdr_pkg::t_q a;
        scdr_pkg::t_q b;
        logic [RB-1:0] up;
    } t_s66;

    typedef struct packed {
        scdr_pkg::t_q t1;
        scdr_pkg::t_q t2;
        scdr_pkg::t_q t3;
        scdr_pkg::t_q t4;
        scdr_pkg::t_q e1;
        scdr_pkg::t_q e2;
        scdr_pkg::t_q e3;
        scdr_pkg::t_q e4;
        scdr_pkg::t_q px;
        scdr_pkg::t_q py;
        scdr_pkg::t_q pz;
        logic          deg;
        logic          neg3;
        logic [RB-1:0] up;
    } t_s67;

    typedef struct packed {
        scdr_pkg::t_q e1;
        scdr_pkg::t_q e2;
        scdr_pkg::t_q dz;
        scdr_pkg::t_q px;
        scdr_pkg::t_q py;
        scdr_pkg::t_q pz;
        logic          deg;
        logic          neg3;
        logic [RB-1:0] up;
    } t_ds;

    typedef struct packed {
        logic [RB-1:0]   rem;
        logic [DQ_W-1:0] quo;
        logic [62:0]     dvd;
        logic            neg;
    } t_dv;

    typedef struct packed {
        t_w dx;
        t_w dy;
        t_w dz;
    } t_sum;

    function automatic scdr_pkg::t_q dir_in(input logic signed [DW-1:0] raw);
        logic signed [DW-1:0] v;
        v = raw;
        if (raw > D_ONE) begin
            v = D_ONE;
        end else if (raw < -D_ONE) begin
            v = -D_ONE;
        end
        return scdr_pkg::t_q'(v) <<< DSH;
    endfunction

    function automatic logic [DW-1:0] dir_out(input t_w d);
        t_w t;
        t = d;
        if (d[WW-1]) begin
            t = d + W_RND;
        end
        t = t >>> DSH;
        if (t > W_ONE) begin
            t = W_ONE;
        end else if (t < -W_ONE) begin
            t = -W_ONE;
        end
        return t[DW-1:0];
    endfunction

    function automatic t_dv div_init(input scdr_pkg::t_q n);
        t_dv          o;
        scdr_pkg::t_q m;
        logic [62:0]  top;
        m     = n[scdr_pkg::QW-1] ? -n : n;
        o.neg = n[scdr_pkg::QW-1];
        o.dvd = {m[32:0], 30'b0};
        top   = o.dvd >> DQ_W;
        o.rem = top[RB-1:0];
        o.quo = '0;
        return o;
    endfunction

    function automatic t_w div_out(input t_dv v);
        t_w q;
        q = t_w'(v.quo);
        return v.neg ? -q : q;
    endfunction

    logic               en;
    logic [LAST:1]      r_vld;

    scdr_pkg::t_dir     r_u [1:66];
    scdr_pkg::t_q       r1_th;
    scdr_pkg::t_q       r1_ph;
    scdr_pkg::t_red     r2_red [0:1];
    logic [61:0]        r2_p1;
    logic [61:0]        r2_p2;
    scdr_pkg::t_lane    r_ser [0:SN][0:3];
    scdr_pkg::t_side    r_sa [0:SN][0:1];
    scdr_pkg::t_sq      r_sq_u [3:ST_SQ0];
    scdr_pkg::t_pc      r32_pc;
    scdr_pkg::t_pc      r33_pc;
    scdr_pkg::t_q       r33_cc;
    scdr_pkg::t_pc      r_pc [ST_SQ0:ST_SQL];
    scdr_pkg::t_sq      r_sq_s [ST_SQ0:ST_SQL];
    logic [RB-1:0]      r_up [ST_SQ0+1:ST_SQL];
    t_s66               r66;
    t_s67               r67;
    t_ds                r_ds [ST_DV0:ST_DVL];
    t_dv                r_dv [ST_DV0:ST_DVL][0:1];
    t_sum               r_sum;
    logic [DW-1:0]      r_out_x;
    logic [DW-1:0]      r_out_y;
    logic [DW-1:0]      r_out_z;

    scdr_pkg::t_q       n_rad;

    assign en      = !r_vld[LAST] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[LAST];
    assign o_new_x = r_out_x;
    assign o_new_y = r_out_y;
    assign o_new_z = r_out_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAST-1:1], i_valid};
        end
    end

    // input, range reduction, squares
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_u[1].u1 <= dir_in(i_old_x);
            r_u[1].u2 <= dir_in(i_old_y);
            r_u[1].u3 <= dir_in(i_old_z);
            r1_th     <= scdr_pkg::t_q'(i_polar_angle) <<< ASH;
            r1_ph     <= scdr_pkg::t_q'(i_azimuth_angle) <<< ASH;
            for (int s = 2; s <= 66; s++) begin
                r_u[s] <= r_u[s-1];
            end
            r2_red[0] <= scdr_pkg::reduce(r1_th);
            r2_red[1] <= scdr_pkg::reduce(r1_ph);
            r2_p1     <= 62'(r_u[1].u1) * 62'(r_u[1].u1);
            r2_p2     <= 62'(r_u[1].u2) * 62'(r_u[1].u2);
            r_sq_u[3] <= '{rem: r2_p1 + r2_p2, root: '0};
            for (int a = 0; a < 2; a++) begin
                r_sa[0][a].r2   <= scdr_pkg::mulq(r2_red[a].r, r2_red[a].r);
                r_sa[0][a].quad <= r2_red[a].quad;
                r_ser[0][2*a]   <= '{prod: '0, mag: '0, neg: 1'b0, q0: '0,
                                     term: r2_red[a].r, sum: r2_red[a].r};
                r_ser[0][2*a+1] <= '{prod: '0, mag: '0, neg: 1'b0, q0: '0,
                                     term: scdr_pkg::Q_ONE, sum: scdr_pkg::Q_ONE};
            end
        end
    end

    // taylor series, four stages per term
    for (genvar k = 1; k <= SN; k++) begin : g_ser
        localparam int N = (k - 1) / scdr_pkg::SER_SUB + 1;
        localparam int J = (k - 1) % scdr_pkg::SER_SUB;

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sa[k] <= r_sa[k-1];
            end
        end

        for (genvar l = 0; l < 4; l++) begin : g_lane
            localparam int D = (l % 2 == 0) ? (2 * N) * (2 * N + 1) : (2 * N - 1) * (2 * N);
            localparam logic [31:0] M = 32'((64'd1 << 32) / D);

            scdr_pkg::t_lane n_ln;
            logic signed [61:0] abs_p;
            logic [61:0]        pm;
            logic [37:0]        qd;
            logic [29:0]        rm;
            logic [30:0]        q;

            always_comb begin
                n_ln  = r_ser[k-1][l];
                abs_p = '0;
                pm    = '0;
                qd    = '0;
                rm    = '0;
                q     = '0;
                unique case (J)
                    0: begin
                        n_ln.prod = 62'(r_ser[k-1][l].term) * 62'(r_sa[k-1][l/2].r2);
                    end
                    1: begin
                        abs_p     = r_ser[k-1][l].prod[61] ? -r_ser[k-1][l].prod
                                                           : r_ser[k-1][l].prod;
                        n_ln.mag  = abs_p[59:30];
                        n_ln.neg  = r_ser[k-1][l].prod[61];
                    end
                    2: begin
                        pm        = 62'(r_ser[k-1][l].mag) * 62'(M);
                        n_ln.q0   = pm[61:32];
                    end
                    default: begin
                        qd        = 38'(r_ser[k-1][l].q0) * 38'(D);
                        rm        = r_ser[k-1][l].mag - qd[29:0];
                        q         = {1'b0, r_ser[k-1][l].q0} + 31'(rm >= 30'(D));
                        n_ln.term = r_ser[k-1][l].neg ? scdr_pkg::t_q'(q)
                                                      : -scdr_pkg::t_q'(q);
                        n_ln.sum  = r_ser[k-1][l].sum + n_ln.term;
                    end
                endcase
            end

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_ser[k][l] <= n_ln;
                end
            end
        end
    end

    // root of ux^2 + uy^2
    for (genvar s = 4; s <= ST_SQ0; s++) begin : g_uroot
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_u[s] <= scdr_pkg::sqrt_step(r_sq_u[s-1], ST_SQ0 - s);
            end
        end
    end

    // quadrant select, cos^2 theta, radicand
    always_comb begin
        n_rad = scdr_pkg::Q_ONE - r33_cc;
        if (n_rad[scdr_pkg::QW-1]) begin
            n_rad = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r32_pc.cth <= scdr_pkg::pick_cos(r_sa[SN][0].quad, r_ser[SN][0].sum,
                                             r_ser[SN][1].sum);
            r32_pc.sph <= scdr_pkg::pick_sin(r_sa[SN][1].quad, r_ser[SN][2].sum,
                                             r_ser[SN][3].sum);
            r32_pc.cph <= scdr_pkg::pick_cos(r_sa[SN][1].quad, r_ser[SN][2].sum,
                                             r_ser[SN][3].sum);
            r33_pc     <= r32_pc;
            r33_cc     <= scdr_pkg::mulq(r32_pc.cth, r32_pc.cth);
            r_pc[ST_SQ0]   <= r33_pc;
            r_sq_s[ST_SQ0] <= '{rem: scdr_pkg::SQ_W'({n_rad[30:0], 30'b0}), root: '0};
            r_up[ST_SQ0+1] <= r_sq_u[ST_SQ0].root;
            for (int s = ST_SQ0 + 2; s <= ST_SQL; s++) begin
                r_up[s] <= r_up[s-1];
            end
            for (int s = ST_SQ0 + 1; s <= ST_SQL; s++) begin
                r_pc[s] <= r_pc[s-1];
            end
        end
    end

    // root of the radicand gives sin theta
    for (genvar s = ST_SQ0 + 1; s <= ST_SQL; s++) begin : g_sroot
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_s[s] <= scdr_pkg::sqrt_step(r_sq_s[s-1], ST_SQL - s);
            end
        end
    end

    // local direction and rotation products
    always_ff @(posedge i_clk) begin
        if (en) begin
            r66.px <= scdr_pkg::mulq(scdr_pkg::t_q'(r_sq_s[ST_SQL].root), r_pc[ST_SQL].cph);
            r66.py <= scdr_pkg::mulq(scdr_pkg::t_q'(r_sq_s[ST_SQL].root), r_pc[ST_SQL].sph);
            r66.pz <= r_pc[ST_SQL].cth;
            r66.a  <= scdr_pkg::mulq(r_u[65].u1, r_u[65].u3);
            r66.b  <= scdr_pkg::mulq(r_u[65].u2, r_u[65].u3);
            r66.up <= r_up[ST_SQL];

            r67.t1   <= scdr_pkg::mulq(r66.a, r66.px);
            r67.t2   <= scdr_pkg::mulq(r_u[66].u2, r66.py);
            r67.t3   <= scdr_pkg::mulq(r66.b, r66.px);
            r67.t4   <= scdr_pkg::mulq(r_u[66].u1, r66.py);
            r67.e1   <= scdr_pkg::mulq(r_u[66].u1, r66.pz);
            r67.e2   <= scdr_pkg::mulq(r_u[66].u2, r66.pz);
            r67.e3   <= scdr_pkg::mulq(scdr_pkg::t_q'(r66.up), r66.px);
            r67.e4   <= scdr_pkg::mulq(r_u[66].u3, r66.pz);
            r67.px   <= r66.px;
            r67.py   <= r66.py;
            r67.pz   <= r66.pz;
            r67.deg  <= (r_u[66].u1 == '0) && (r_u[66].u2 == '0);
            r67.neg3 <= r_u[66].u3[scdr_pkg::QW-1];
            r67.up   <= r66.up;

            r_ds[ST_DV0].e1   <= r67.e1;
            r_ds[ST_DV0].e2   <= r67.e2;
            r_ds[ST_DV0].dz   <= r67.e4 - r67.e3;
            r_ds[ST_DV0].px   <= r67.px;
            r_ds[ST_DV0].py   <= r67.py;
            r_ds[ST_DV0].pz   <= r67.pz;
            r_ds[ST_DV0].deg  <= r67.deg;
            r_ds[ST_DV0].neg3 <= r67.neg3;
            r_ds[ST_DV0].up   <= r67.up;
            r_dv[ST_DV0][0]   <= div_init(r67.t1 - r67.t2);
            r_dv[ST_DV0][1]   <= div_init(r67.t3 + r67.t4);
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar s = ST_DV0 + 1; s <= ST_DVL; s++) begin : g_div
        localparam int B = ST_DVL - s;

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_ds[s] <= r_ds[s-1];
            end
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            t_dv         n_dv;
            logic [RB:0] rem2;
            logic [RB:0] dif;

            always_comb begin
                n_dv = r_dv[s-1][l];
                rem2 = {r_dv[s-1][l].rem, r_dv[s-1][l].dvd[B]};
                dif  = rem2 - {1'b0, r_ds[s-1].up};
                if (rem2 >= {1'b0, r_ds[s-1].up}) begin
                    n_dv.rem    = dif[RB-1:0];
                    n_dv.quo[B] = 1'b1;
                end else begin
                    n_dv.rem    = rem2[RB-1:0];
                end
            end

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_dv[s][l] <= n_dv;
                end
            end
        end
    end

    // final sums, pass-through axis case, output scaling
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_ds[ST_DVL].deg) begin
                r_sum.dx <= r_ds[ST_DVL].neg3 ? -t_w'(r_ds[ST_DVL].px) : t_w'(r_ds[ST_DVL].px);
                r_sum.dy <= t_w'(r_ds[ST_DVL].py);
                r_sum.dz <= r_ds[ST_DVL].neg3 ? -t_w'(r_ds[ST_DVL].pz) : t_w'(r_ds[ST_DVL].pz);
            end else begin
                r_sum.dx <= div_out(r_dv[ST_DVL][0]) + t_w'(r_ds[ST_DVL].e1);
                r_sum.dy <= div_out(r_dv[ST_DVL][1]) + t_w'(r_ds[ST_DVL].e2);
                r_sum.dz <= t_w'(r_ds[ST_DVL].dz);
            end
            r_out_x <= dir_out(r_sum.dx);
            r_out_y <= dir_out(r_sum.dy);
            r_out_z <= dir_out(r_sum.dz);
        end
    end

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_new_x <= D_ONE && o_new_x >= -D_ONE &&
                     o_new_y <= D_ONE && o_new_y >= -D_ONE &&
                     o_new_z <= D_ONE && o_new_z >= -D_ONE))
        else $error("new direction beyond unit range");

    a_sin_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_SQL] |-> (r_sq_s[ST_SQL].root <= RB'(scdr_pkg::Q_ONE)))
        else $error("sin theta root above one");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[ST_DVL] && !r_ds[ST_DVL].deg) |->
            (r_dv[ST_DVL][0].rem < r_ds[ST_DVL].up && r_dv[ST_DVL][1].rem < r_ds[ST_DVL].up))
        else $error("divider remainder not below divisor");

    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output beat valid after reset");

endmodule
